[design/urm_pkg.sv]
// Shared types and constants for the ultrasonic ranger with median filter.
// Holds register indexes, reset values and round event codes; no dependencies.
`default_nettype none

package urm_pkg;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int WIDTH_W = 17;     // echo width, can reach echo_timeout + 1
    localparam int MED_W   = 16;

    // register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_TRIGGER_TICKS = 3'd0;
    localparam logic [2:0] REG_START_TIMEOUT = 3'd1;
    localparam logic [2:0] REG_ECHO_TIMEOUT  = 3'd2;
    localparam logic [2:0] REG_MIN_ROUNDS    = 3'd3;
    localparam logic [2:0] REG_MAX_ROUNDS    = 3'd4;
    localparam logic [2:0] REG_ENOUGH_COUNT  = 3'd5;

    localparam logic [9:0]  RST_TRIGGER_TICKS = 10'd10;
    localparam logic [15:0] RST_START_TIMEOUT = 16'd5000;
    localparam logic [15:0] RST_ECHO_TIMEOUT  = 16'd60000;
    localparam logic [5:0]  RST_MIN_ROUNDS    = 6'd42;
    localparam logic [7:0]  RST_MAX_ROUNDS    = 8'd100;
    localparam logic [5:0]  RST_ENOUGH_COUNT  = 6'd21;

    // round outcome codes
    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_VALID     = 2'd1;
    localparam logic [1:0] EV_TIMEOUT   = 2'd2;
    localparam logic [1:0] EV_NOT_FIRED = 2'd3;

    typedef struct packed {
        logic [9:0]  trigger_ticks;
        logic [15:0] start_timeout;
        logic [15:0] echo_timeout;
        logic [5:0]  min_rounds;
        logic [7:0]  max_rounds;
        logic [5:0]  enough_count;
    } cfg_t;

endpackage

`default_nettype wire

[design/ultrasonic_ranger_median.sv]
// Ultrasonic ranger: trigger/echo sequencing per tick, sorted width store, lower median.
// Depends on urm_pkg for register indexes, reset values and event codes.
//
// Each request is one tick carrying start_req and echo_level, and yields exactly one
// response with the trigger level, round outcome and, on the finishing tick, the lower
// median of the stored echo widths. A request that stores no reading and finishes no
// run goes through accept, then load of the output register. A request that stores
// a valid reading writes it straight in when the store is empty, else first shifts up
// each stored entry larger than the new width; the sorted store is a single memory
// with one read and one write port and the insertion shifts one entry per cycle. A
// finishing tick with readings adds the median read (S_MRD, S_MWT). A new request is
// taken while a response still waits in the output register. The store needs no
// clearing after reset.
`default_nettype none

module ultrasonic_ranger_median #(
    parameter int STORE_DEPTH = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          start_req,
    input  wire logic                          echo_level,
    // response channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               trigger_level,
    output logic [1:0]                         round_event,
    output logic                               done_res,
    output logic                               result_valid,
    output logic [urm_pkg::MED_W-1:0]          median_width,
    output logic                               busy_res,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [urm_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [urm_pkg::PDATA_W-1:0]   pwdata,
    output logic [urm_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);
    import urm_pkg::*;

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_RISE,
        PH_MEAS
    } phase_t;

    typedef enum logic [2:0] {
        S_READY,
        S_INS,
        S_CMP,
        S_MRD,
        S_MWT,
        S_PUSH
    } fsm_t;

    // ---------------------------------------------------------------- config
    cfg_t cfg_reg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_ticks <= RST_TRIGGER_TICKS;
            cfg_reg.start_timeout <= RST_START_TIMEOUT;
            cfg_reg.echo_timeout  <= RST_ECHO_TIMEOUT;
            cfg_reg.min_rounds    <= RST_MIN_ROUNDS;
            cfg_reg.max_rounds    <= RST_MAX_ROUNDS;
            cfg_reg.enough_count  <= RST_ENOUGH_COUNT;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_TRIGGER_TICKS: cfg_reg.trigger_ticks <= pwdata[9:0];
                REG_START_TIMEOUT: cfg_reg.start_timeout <= pwdata[15:0];
                REG_ECHO_TIMEOUT:  cfg_reg.echo_timeout  <= pwdata[15:0];
                REG_MIN_ROUNDS:    cfg_reg.min_rounds    <= pwdata[5:0];
                REG_MAX_ROUNDS:    cfg_reg.max_rounds    <= pwdata[7:0];
                REG_ENOUGH_COUNT:  cfg_reg.enough_count  <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_TRIGGER_TICKS: prdata = {22'd0, cfg_reg.trigger_ticks};
            REG_START_TIMEOUT: prdata = {16'd0, cfg_reg.start_timeout};
            REG_ECHO_TIMEOUT:  prdata = {16'd0, cfg_reg.echo_timeout};
            REG_MIN_ROUNDS:    prdata = {26'd0, cfg_reg.min_rounds};
            REG_MAX_ROUNDS:    prdata = {24'd0, cfg_reg.max_rounds};
            REG_ENOUGH_COUNT:  prdata = {26'd0, cfg_reg.enough_count};
            default:           prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- state
    fsm_t                 fsm_reg;
    phase_t               phase_reg;
    logic [WIDTH_W-1:0]   elapsed_reg;
    logic [7:0]           round_cnt_reg;
    logic [CW-1:0]        valid_cnt_reg;
    logic [AW-1:0]        cur_reg;
    logic [WIDTH_W-1:0]   width_reg;
    logic                 need_med_reg;

    logic                 res_trig_reg;
    logic [1:0]           res_ev_reg;
    logic                 res_done_reg;
    logic                 res_rv_reg;
    logic [MED_W-1:0]     res_med_reg;
    logic                 res_busy_reg;

    logic                 out_valid_reg;
    logic                 out_trig_reg;
    logic [1:0]           out_ev_reg;
    logic                 out_done_reg;
    logic                 out_rv_reg;
    logic [MED_W-1:0]     out_med_reg;
    logic                 out_busy_reg;

    // store
    logic [WIDTH_W-1:0]   mem [STORE_DEPTH];
    logic [WIDTH_W-1:0]   mem_rdata_reg;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WIDTH_W-1:0]   mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;

    logic                 in_accept;
    logic                 out_take;

    assign in_stall  = (fsm_reg != S_READY);
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;

    // ---------------------------------------------------------------- per tick
    phase_t               phase_next;
    logic [WIDTH_W-1:0]   elapsed_inc;
    logic [WIDTH_W-1:0]   elapsed_next;
    logic [7:0]           round_next;
    logic [CW-1:0]        valid_next;
    logic [8:0]           rounds;
    logic [1:0]           ev_c;
    logic                 trig_c;
    logic                 busy_c;
    logic                 done_c;
    logic                 start_c;
    logic                 ins_c;

    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_inc  = elapsed_reg + WIDTH_W'(1);
        elapsed_next = elapsed_reg;
        ev_c         = EV_NONE;
        trig_c       = 1'b0;
        busy_c       = 1'b0;
        done_c       = 1'b0;
        start_c      = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start_req)
                begin
                    start_c      = 1'b1;
                    busy_c       = 1'b1;
                    elapsed_next = '0;
                    phase_next   = PH_TRIG;
                end
            end
            PH_TRIG:
            begin
                trig_c       = 1'b1;
                busy_c       = 1'b1;
                elapsed_next = elapsed_inc;
                if (elapsed_inc > WIDTH_W'(cfg_reg.trigger_ticks))
                begin
                    phase_next   = PH_RISE;
                    elapsed_next = '0;
                end
            end
            PH_RISE:
            begin
                busy_c       = 1'b1;
                elapsed_next = elapsed_inc;
                if (echo_level)
                begin
                    phase_next   = PH_MEAS;
                    elapsed_next = '0;
                end
                else if (elapsed_inc > WIDTH_W'(cfg_reg.start_timeout))
                begin
                    ev_c = EV_NOT_FIRED;
                end
            end
            PH_MEAS:
            begin
                busy_c       = 1'b1;
                elapsed_next = elapsed_inc;
                if (!echo_level)
                begin
                    ev_c = EV_VALID;
                end
                else if (elapsed_inc > WIDTH_W'(cfg_reg.echo_timeout))
                begin
                    ev_c = EV_TIMEOUT;
                end
            end
            default: ;
        endcase

        // drop readings once the store is full
        ins_c      = (ev_c == EV_VALID) && (32'(valid_cnt_reg) < 32'(STORE_DEPTH));
        valid_next = start_c ? '0 : valid_cnt_reg + CW'(ins_c);
        round_next = start_c ? 8'd0 : round_cnt_reg;
        rounds     = {1'b0, round_cnt_reg} + 9'd1;

        if (ev_c != EV_NONE)
        begin
            elapsed_next = '0;
            round_next   = rounds[7:0];
            if ((rounds > {1'b0, cfg_reg.max_rounds}) ||
                ((rounds > {3'b0, cfg_reg.min_rounds}) &&
                 (32'(valid_next) > 32'(cfg_reg.enough_count))))
            begin
                done_c     = 1'b1;
                busy_c     = 1'b0;
                phase_next = PH_IDLE;
            end
            else
            begin
                phase_next = PH_TRIG;
            end
        end
    end

    // lower median sits at rank (count+1)/2
    logic [CW:0]   med_rank;
    logic [AW-1:0] med_addr;

    always_comb
    begin
        med_rank = ((CW + 1)'(valid_cnt_reg) + (CW + 1)'(1)) >> 1;
        med_addr = AW'(med_rank - (CW + 1)'(1));
    end

    // ---------------------------------------------------------------- store port control
    logic shift_c;

    assign shift_c = (mem_rdata_reg > width_reg);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_reg;
        mem_wdata = width_reg;
        mem_re    = 1'b0;
        mem_raddr = cur_reg - AW'(1);
        case (fsm_reg)
            S_INS:
            begin
                if (cur_reg == '0)
                begin
                    mem_we = 1'b1;
                end
                else
                begin
                    mem_re = 1'b1;
                end
            end
            S_CMP:
            begin
                mem_we = 1'b1;
                if (shift_c)
                begin
                    // move the larger entry up, fetch the next one below
                    mem_wdata = mem_rdata_reg;
                    mem_raddr = cur_reg - AW'(2);
                    mem_re    = (cur_reg != AW'(1));
                end
            end
            S_MRD:
            begin
                mem_re    = 1'b1;
                mem_raddr = med_addr;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= S_READY;
            phase_reg     <= PH_IDLE;
            elapsed_reg   <= '0;
            round_cnt_reg <= '0;
            valid_cnt_reg <= '0;
            need_med_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a push in the same cycle reloads the register instead
            if (out_take && (fsm_reg != S_PUSH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (fsm_reg)
                S_READY:
                begin
                    if (in_accept)
                    begin
                        phase_reg     <= phase_next;
                        elapsed_reg   <= elapsed_next;
                        round_cnt_reg <= round_next;
                        valid_cnt_reg <= valid_next;
                        cur_reg       <= AW'(valid_cnt_reg);
                        width_reg     <= elapsed_inc;
                        need_med_reg  <= done_c && (valid_next != '0);
                        res_trig_reg  <= trig_c;
                        res_ev_reg    <= ev_c;
                        res_done_reg  <= done_c;
                        res_rv_reg    <= 1'b0;
                        res_med_reg   <= '0;
                        res_busy_reg  <= busy_c;
                        if (ins_c)
                        begin
                            fsm_reg <= S_INS;
                        end
                        else if (done_c && (valid_next != '0))
                        begin
                            fsm_reg <= S_MRD;
                        end
                        else
                        begin
                            fsm_reg <= S_PUSH;
                        end
                    end
                end
                S_INS:
                begin
                    if (cur_reg == '0)
                    begin
                        fsm_reg <= need_med_reg ? S_MRD : S_PUSH;
                    end
                    else
                    begin
                        fsm_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    if (shift_c)
                    begin
                        cur_reg <= cur_reg - AW'(1);
                        if (cur_reg == AW'(1))
                        begin
                            fsm_reg <= S_INS;
                        end
                    end
                    else
                    begin
                        fsm_reg <= need_med_reg ? S_MRD : S_PUSH;
                    end
                end
                S_MRD:
                begin
                    fsm_reg <= S_MWT;
                end
                S_MWT:
                begin
                    res_rv_reg  <= 1'b1;
                    res_med_reg <= mem_rdata_reg[WIDTH_W-1] ? '1 : mem_rdata_reg[MED_W-1:0];
                    fsm_reg     <= S_PUSH;
                end
                S_PUSH:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_trig_reg  <= res_trig_reg;
                        out_ev_reg    <= res_ev_reg;
                        out_done_reg  <= res_done_reg;
                        out_rv_reg    <= res_rv_reg;
                        out_med_reg   <= res_med_reg;
                        out_busy_reg  <= res_busy_reg;
                        fsm_reg       <= S_READY;
                    end
                end
                default:
                begin
                    fsm_reg <= S_READY;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign trigger_level = out_trig_reg;
    assign round_event   = out_ev_reg;
    assign done_res      = out_done_reg;
    assign result_valid  = out_rv_reg;
    assign median_width  = out_med_reg;
    assign busy_res      = out_busy_reg;

    // ---------------------------------------------------------------- checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(valid_cnt_reg) <= 32'(STORE_DEPTH))
        else $error("stored reading count beyond store depth");

    a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("store read and write hit the same entry");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (phase_reg == PH_IDLE) && start_req) |=>
        ((valid_cnt_reg == '0) && (round_cnt_reg == 8'd0) && (phase_reg == PH_TRIG)))
        else $error("run start did not clear counters");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> (!busy_res && (round_event != EV_NONE)))
        else $error("finish response without a round outcome or still busy");

endmodule

`default_nettype wire
